// ===== sv/tei_pkg.sv =====
package tei_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 16;

  localparam int IDX_W     = 4;
  localparam int TIME_W    = 32;
  localparam int FLOW_W    = 32;
  localparam int GAIN_W    = 32;
  localparam int COUNT_W   = 5;
  localparam int FLUX_W    = 48;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam int S_TDATA_W = 104;
  localparam int M_TDATA_W = 48;

  localparam int QUEUE_DEPTH = 2;

  localparam int QUOT_W = 41;
  localparam int PROD_W = 73;
  localparam int SCALED_W = 57;

  localparam logic [63:0]         QUOT_CAP = 64'h0000_0100_0000_0000;
  localparam logic [SCALED_W-1:0] POS_MAX  = 57'h7FFF_FFFF_FFFF;
  localparam logic [SCALED_W-1:0] NEG_MAG  = 57'h8000_0000_0000;

  localparam logic [TIME_W-1:0]  ERUPTION_RESET = 32'd0;
  localparam logic [GAIN_W-1:0]  GAIN_RESET     = 32'd65536;
  localparam logic [COUNT_W-1:0] COUNT_RESET    = 5'd2;

  localparam logic ACTION_LOAD  = 1'b0;
  localparam logic ACTION_QUERY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ERUPTION = 2'd0,
    CFG_GAIN     = 2'd1,
    CFG_COUNT    = 2'd2
  } cfg_reg_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EARLY = 2'd1,
    STAT_LATE  = 2'd2,
    STAT_BAD   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_DROP  = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_EARLY = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [IDX_W-1:0]   idx;
    logic [TIME_W-1:0]  etime;
    logic [FLOW_W-1:0]  eflow;
    logic [TIME_W-1:0]  delta;
  } item_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain;
    logic [COUNT_W-1:0] count;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

// ===== sv/timed_emission_interpolator_top.sv =====
// Piecewise linear emission flux from a breakpoint table.
// The slave stream carries load and query transactions, told apart by
// tuser. A load writes one table slot and gives no result; a query gives
// one master transaction with the scaled flux in tdata and the status in
// tuser. Registers are written over the cfg channel, which is always ready.
// Accepted transactions wait in a two-entry queue in front of the execution
// engine. A load is written to the table from the idle state and the engine
// stays idle; a load whose index lies past the table is dropped. A query
// before the eruption or with fewer than two breakpoints in use goes straight
// to the output stage, one after the last breakpoint first reads that
// breakpoint's time, and an interpolated query runs the segment scan (one
// table read per cycle) and the 64-step bit-serial divider.
// The result sits in an output register, so the queue keeps filling while
// the receiver stalls; the engine waits only when a second result is ready.
// Reset empties the queue and the output register and restores the
// registers to eruption time 0, gain 1.0 and two breakpoints in use. The
// table contents are undefined until written.
module timed_emission_interpolator_top #(
  parameter int TABLE_DEPTH = tei_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // entry_index, entry_time, entry_flow, query_time, zero pad
  input  logic [tei_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // action
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // flux
  output logic [tei_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // status
  output logic [tei_pkg::STATUS_W-1:0]   m_axis_tuser,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tei_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tei_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import tei_pkg::*;

  logic        push, pop;
  item_t       push_item, head_item;
  queue_stat_t qstat;
  cfg_t        cfg;

  tei_front #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .queue_i       (qstat),
    .push_o        (push),
    .item_o        (push_item),
    .cfg_o         (cfg)
  );

  tei_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (head_item),
    .stat_o (qstat)
  );

  tei_back #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (!qstat.empty),
    .item_i        (head_item),
    .pop_o         (pop),
    .cfg_i         (cfg),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  a_zero_on_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != STAT_OK) |-> m_axis_tdata == '0)
    else $error("nonzero flux with error status");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !qstat.full)
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !qstat.empty)
    else $error("queue read while empty");

endmodule

// ===== sv/tei_front.sv =====
module tei_front #(
  parameter int TABLE_DEPTH = tei_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // entry_index, entry_time, entry_flow, query_time, zero pad
  input  logic [tei_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // action
  input  logic                         s_axis_tuser,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tei_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tei_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  tei_pkg::queue_stat_t         queue_i,
  output logic                         push_o,
  output tei_pkg::item_t               item_o,
  output tei_pkg::cfg_t                cfg_o
);
  import tei_pkg::*;

  logic [TIME_W-1:0]  eruption_q;
  logic [GAIN_W-1:0]  gain_q;
  logic [COUNT_W-1:0] count_q;
  logic [TIME_W-1:0]  query_time;
  logic               cfg_write;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eruption_q <= ERUPTION_RESET;
      gain_q     <= GAIN_RESET;
      count_q    <= COUNT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index_i)
        CFG_ERUPTION: eruption_q <= cfg_data_i[TIME_W-1:0];
        CFG_GAIN:     gain_q <= cfg_data_i[GAIN_W-1:0];
        CFG_COUNT:    count_q <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.gain  = gain_q;
  assign cfg_o.count = count_q;

  assign query_time = s_axis_tdata[99:68];

  always_comb begin
    item_o.idx   = s_axis_tdata[3:0];
    item_o.etime = s_axis_tdata[35:4];
    item_o.eflow = s_axis_tdata[67:36];
    item_o.delta = query_time - eruption_q;
    if (s_axis_tuser == ACTION_LOAD) begin
      item_o.kind = (int'(item_o.idx) < TABLE_DEPTH) ? KIND_LOAD : KIND_DROP;
    end else begin
      item_o.kind = (query_time < eruption_q) ? KIND_EARLY : KIND_QUERY;
    end
  end

  assign s_axis_tready = !queue_i.full;
  assign push_o        = s_axis_tvalid && s_axis_tready;

endmodule

// ===== sv/tei_queue.sv =====
module tei_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  tei_pkg::item_t       item_i,
  input  logic                 pop_i,
  output tei_pkg::item_t       item_o,
  output tei_pkg::queue_stat_t stat_o
);
  import tei_pkg::*;

  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  item_t          mem_q [QUEUE_DEPTH];
  logic [QW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]  fill_q, fill_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = QW'(int'(wr_ptr_q) + 1);
    end
    if (pop_i) begin
      rd_ptr_d = QW'(int'(rd_ptr_q) + 1);
    end
    if (push_i && !pop_i) begin
      fill_d = NW'(int'(fill_q) + 1);
    end else if (pop_i && !push_i) begin
      fill_d = NW'(int'(fill_q) - 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (int'(fill_q) == QUEUE_DEPTH);
  assign stat_o.empty = (fill_q == '0);

endmodule

// ===== sv/tei_back.sv =====
module tei_back #(
  parameter int TABLE_DEPTH = tei_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  tei_pkg::item_t                item_i,
  output logic                          pop_o,
  input  tei_pkg::cfg_t                 cfg_i,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // flux
  output logic [tei_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // status
  output logic [tei_pkg::STATUS_W-1:0]  m_axis_tuser
);
  import tei_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_LAST  = 12'b0000_0000_0010,
    S_SCAN  = 12'b0000_0000_0100,
    S_PAIR0 = 12'b0000_0000_1000,
    S_PAIR1 = 12'b0000_0001_0000,
    S_MUL   = 12'b0000_0010_0000,
    S_DIV   = 12'b0000_0100_0000,
    S_ADD   = 12'b0000_1000_0000,
    S_SCLO  = 12'b0001_0000_0000,
    S_SCHI  = 12'b0010_0000_0000,
    S_FINAL = 12'b0100_0000_0000,
    S_OUT   = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [TIME_W-1:0] times_mem [TABLE_DEPTH];
  logic [FLOW_W-1:0] flows_mem [TABLE_DEPTH];
  logic [TIME_W-1:0] times_rd_q;
  logic [FLOW_W-1:0] flows_rd_q;
  logic              t_rd_en, f_rd_en, wr_en;
  logic [AW-1:0]     t_rd_addr, f_rd_addr, wr_addr;

  logic [CW-1:0]     n_eff;
  logic              n_ok;
  logic              scan_more;
  logic              out_free, out_load;
  logic              out_valid_q, out_valid_d;
  logic [FLUX_W-1:0] out_flux_q;
  status_e           out_status_q;

  logic [AW-1:0]       h_q;
  logic [TIME_W-1:0]   d_q, t0_q, t1_q, anum_q, den_q;
  logic [FLOW_W-1:0]   f0_q, adf_q;
  logic                neg_q, vneg_q;
  logic [63:0]         dvd_q;
  logic [31:0]         rem_q;
  logic [5:0]          cnt_q;
  logic [QUOT_W-1:0]   mag_q;
  logic [63:0]         lo_q;
  logic [QUOT_W-1:0]   hi_q;
  logic [FLUX_W-1:0]   res_flux_q;
  status_e             res_status_q;

  logic [32:0]         rem_sh;
  logic                rem_ge;
  logic [31:0]         rem_nx;
  logic [QUOT_W-1:0]   quot_c;
  logic [QUOT_W-1:0]   f0_ext;
  logic [PROD_W-1:0]   prod;
  logic [SCALED_W-1:0] scaled, clamp_pos, clamp_neg, neg_val;
  logic [FLUX_W-1:0]   flux_fin;

  always_comb begin
    if (int'(cfg_i.count) > TABLE_DEPTH) begin
      n_eff = CW'(TABLE_DEPTH);
    end else begin
      n_eff = CW'(cfg_i.count);
    end
  end

  assign n_ok      = int'(n_eff) >= 2;
  assign scan_more = ((int'(h_q) + 2) < int'(n_eff)) && (times_rd_q < d_q);
  assign out_free  = !out_valid_q || m_axis_tready;

  // One step of the restoring divider.
  assign rem_sh = {rem_q, dvd_q[63]};
  assign rem_ge = rem_sh >= {1'b0, den_q};
  assign rem_nx = rem_ge ? 32'(rem_sh - {1'b0, den_q}) : rem_sh[31:0];

  assign quot_c = (dvd_q > QUOT_CAP) ? QUOT_CAP[QUOT_W-1:0] : dvd_q[QUOT_W-1:0];
  assign f0_ext = QUOT_W'(f0_q);

  assign prod      = {hi_q, 32'd0} + PROD_W'(lo_q);
  assign scaled    = prod[PROD_W-1:16];
  assign clamp_pos = (scaled > POS_MAX) ? POS_MAX : scaled;
  assign clamp_neg = (scaled > NEG_MAG) ? NEG_MAG : scaled;
  assign neg_val   = '0 - clamp_neg;
  assign flux_fin  = vneg_q ? neg_val[FLUX_W-1:0] : clamp_pos[FLUX_W-1:0];

  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = AW'(item_i.idx);
    t_rd_en   = 1'b0;
    t_rd_addr = '0;
    f_rd_en   = 1'b0;
    f_rd_addr = '0;
    out_load  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (valid_i) begin
          pop_o = 1'b1;
          unique case (item_i.kind)
            KIND_LOAD:  wr_en = 1'b1;
            KIND_DROP:  ;
            KIND_EARLY: state_d = S_OUT;
            KIND_QUERY: begin
              if (!n_ok) begin
                state_d = S_OUT;
              end else begin
                t_rd_en   = 1'b1;
                t_rd_addr = AW'(int'(n_eff) - 1);
                state_d   = S_LAST;
              end
            end
            default: ;
          endcase
        end
      end
      S_LAST: begin
        if (d_q > times_rd_q) begin
          state_d = S_OUT;
        end else begin
          t_rd_en   = 1'b1;
          t_rd_addr = AW'(1);
          state_d   = S_SCAN;
        end
      end
      S_SCAN: begin
        t_rd_en = 1'b1;
        if (scan_more) begin
          t_rd_addr = AW'(int'(h_q) + 2);
        end else begin
          t_rd_addr = h_q;
          f_rd_en   = 1'b1;
          f_rd_addr = h_q;
          state_d   = S_PAIR0;
        end
      end
      S_PAIR0: begin
        f_rd_en   = 1'b1;
        f_rd_addr = AW'(int'(h_q) + 1);
        state_d   = S_PAIR1;
      end
      S_PAIR1: state_d = (t1_q <= t0_q) ? S_OUT : S_MUL;
      S_MUL:   state_d = S_DIV;
      S_DIV:   state_d = (cnt_q == 6'd63) ? S_ADD : S_DIV;
      S_ADD:   state_d = S_SCLO;
      S_SCLO:  state_d = S_SCHI;
      S_SCHI:  state_d = S_FINAL;
      S_FINAL: state_d = S_OUT;
      S_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      times_mem[wr_addr] <= item_i.etime;
      flows_mem[wr_addr] <= item_i.eflow;
    end
    if (t_rd_en) begin
      times_rd_q <= times_mem[t_rd_addr];
    end
    if (f_rd_en) begin
      flows_rd_q <= flows_mem[f_rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        d_q        <= item_i.delta;
        res_flux_q <= '0;
        res_status_q <= (item_i.kind == KIND_EARLY) ? STAT_EARLY : STAT_BAD;
      end
      S_LAST: begin
        h_q          <= '0;
        res_status_q <= STAT_LATE;
      end
      S_SCAN: begin
        if (scan_more) begin
          h_q <= AW'(int'(h_q) + 1);
        end else begin
          t1_q <= times_rd_q;
        end
      end
      S_PAIR0: begin
        t0_q <= times_rd_q;
        f0_q <= flows_rd_q;
      end
      S_PAIR1: begin
        res_status_q <= STAT_BAD;
        adf_q  <= (flows_rd_q >= f0_q) ? flows_rd_q - f0_q : f0_q - flows_rd_q;
        anum_q <= (d_q >= t0_q) ? d_q - t0_q : t0_q - d_q;
        den_q  <= t1_q - t0_q;
        neg_q  <= (flows_rd_q < f0_q) != (d_q < t0_q);
      end
      S_MUL: begin
        dvd_q <= 64'(adf_q) * 64'(anum_q);
        rem_q <= '0;
        cnt_q <= '0;
      end
      S_DIV: begin
        rem_q <= rem_nx;
        dvd_q <= {dvd_q[62:0], rem_ge};
        cnt_q <= cnt_q + 6'd1;
      end
      S_ADD: begin
        if (!neg_q) begin
          mag_q  <= f0_ext + quot_c;
          vneg_q <= 1'b0;
        end else if (quot_c > f0_ext) begin
          mag_q  <= quot_c - f0_ext;
          vneg_q <= 1'b1;
        end else begin
          mag_q  <= f0_ext - quot_c;
          vneg_q <= 1'b0;
        end
      end
      S_SCLO: lo_q <= 64'(mag_q[31:0]) * 64'(cfg_i.gain);
      S_SCHI: hi_q <= QUOT_W'(mag_q[QUOT_W-1:32]) * QUOT_W'(cfg_i.gain);
      S_FINAL: begin
        res_flux_q   <= flux_fin;
        res_status_q <= STAT_OK;
      end
      S_OUT: ;
      default: ;
    endcase
    if (out_load) begin
      out_flux_q   <= res_flux_q;
      out_status_q <= res_status_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_flux_q;
  assign m_axis_tuser  = out_status_q;

endmodule
